>>> rtl/rsa_pkg.sv
// Package for the rational sum accumulator: default widths, controller state
// type and the command and status structs between controller and datapath.
// Depends on nothing.
`timescale 1ns / 1ps

package rsa_pkg;

   localparam int TERM_WIDTH_DEFAULT = 32;
   localparam int SUM_WIDTH_DEFAULT  = 63;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_CHECK,
      ST_GCD,
      ST_DIV,
      ST_COMMIT,
      ST_DONE
   } rsa_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // take the input word, apply restart
      logic mul_step;   // one shift-and-add step of the three products
      logic check;      // range check, then load the GCD and divider registers
      logic gcd_step;   // one binary GCD step
      logic div_step;   // one restoring division step on both parts
      logic commit;     // write the reduced sum into the accumulator
      logic out_load;   // load the result register
   } rsa_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic term_den_zero;  // incoming term has a zero denominator
      logic fits;           // unreduced sum fits the accumulator width
      logic gcd_done;       // one GCD operand has reached zero
   } rsa_status_type;

endpackage

>>> rtl/rsa_ctrl.sv
// Controller of the rational sum accumulator: the sequencing state machine,
// the step counter and the result valid flag. Depends on rsa_pkg.
`timescale 1ns / 1ps

module rsa_ctrl #(
   parameter int TERM_WIDTH = rsa_pkg::TERM_WIDTH_DEFAULT,
   parameter int SUM_WIDTH  = rsa_pkg::SUM_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  rsa_pkg::rsa_status_type status,
   output rsa_pkg::rsa_cmd_type    cmd
);

   localparam int CNT_MAX = (TERM_WIDTH > SUM_WIDTH) ? TERM_WIDTH : SUM_WIDTH;
   localparam int CW      = $clog2(CNT_MAX);

   rsa_pkg::rsa_state_type state_ff, state_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   cnt_zero;
   logic                   out_free;

   assign cnt_zero = (cnt_ff == '0);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rsa_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = status.term_den_zero ? rsa_pkg::ST_DONE : rsa_pkg::ST_MUL;
            end
         end
         rsa_pkg::ST_MUL: begin
            if (cnt_zero) state_in = rsa_pkg::ST_CHECK;
         end
         rsa_pkg::ST_CHECK: begin
            state_in = status.fits ? rsa_pkg::ST_GCD : rsa_pkg::ST_DONE;
         end
         rsa_pkg::ST_GCD: begin
            if (status.gcd_done) state_in = rsa_pkg::ST_DIV;
         end
         rsa_pkg::ST_DIV: begin
            if (cnt_zero) state_in = rsa_pkg::ST_COMMIT;
         end
         rsa_pkg::ST_COMMIT: begin
            state_in = rsa_pkg::ST_DONE;
         end
         rsa_pkg::ST_DONE: begin
            if (out_free) state_in = rsa_pkg::ST_IDLE;
         end
         default: begin
            state_in = rsa_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         rsa_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         rsa_pkg::ST_MUL: begin
            cmd.mul_step = 1'b1;
         end
         rsa_pkg::ST_CHECK: begin
            cmd.check = 1'b1;
         end
         rsa_pkg::ST_GCD: begin
            cmd.gcd_step = !status.gcd_done;
         end
         rsa_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         rsa_pkg::ST_COMMIT: begin
            cmd.commit = 1'b1;
         end
         rsa_pkg::ST_DONE: begin
            cmd.out_load = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // The counter counts down the multiply steps, then the division steps.
   always_comb begin
      cnt_in = cnt_ff;
      if (state_ff == rsa_pkg::ST_IDLE) begin
         cnt_in = CW'(TERM_WIDTH - 1);
      end else if (state_ff == rsa_pkg::ST_GCD) begin
         cnt_in = CW'(SUM_WIDTH - 1);
      end else if ((state_ff == rsa_pkg::ST_MUL) || (state_ff == rsa_pkg::ST_DIV)) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsa_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

>>> rtl/rsa_dp.sv
// Datapath of the rational sum accumulator: accumulator, shift-and-add
// multipliers, binary GCD, two restoring dividers and the result register.
// Depends on rsa_pkg; driven by rsa_ctrl.
`timescale 1ns / 1ps

module rsa_dp #(
   parameter int TERM_WIDTH = rsa_pkg::TERM_WIDTH_DEFAULT,
   parameter int SUM_WIDTH  = rsa_pkg::SUM_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_restart,
   input  logic [TERM_WIDTH-1:0]   in_term_num,
   input  logic [TERM_WIDTH-1:0]   in_term_den,
   input  rsa_pkg::rsa_cmd_type    cmd,
   output rsa_pkg::rsa_status_type status,
   output logic [SUM_WIDTH-1:0]    out_sum_num,
   output logic [SUM_WIDTH-1:0]    out_sum_den,
   output logic                    out_overflow,
   output logic                    out_zero_den_error
);

   localparam int TW = TERM_WIDTH;
   localparam int SW = SUM_WIDTH;
   localparam int PW = SUM_WIDTH + TERM_WIDTH;

   logic [SW-1:0] acc_num_ff, acc_den_ff;
   logic          ovf_ff;
   logic [TW-1:0] tn_ff, td_ff;
   logic          zden_ff;
   logic [PW-1:0] p1_ff, p2_ff, pd_ff;
   logic [PW-1:0] p1_in, p2_in, pd_in;
   logic [SW:0]   nn_sum;
   logic [SW-1:0] a_ff, b_ff;
   logic [SW-1:0] qn_ff, qd_ff, rn_ff, rd_ff;
   logic [SW-1:0] divisor;
   logic [SW:0]   rn_sh, rd_sh;
   logic          rn_ge, rd_ge;
   logic [SW-1:0] a_minus_b, b_minus_a;
   logic [SW-1:0] res_num_ff, res_den_ff;
   logic          res_ovf_ff, res_zden_ff;

   // Products are built most significant term bit first: p = 2p + bit*acc.
   assign p1_in = {p1_ff[PW-2:0], 1'b0} + (td_ff[TW-1] ? {{TW{1'b0}}, acc_num_ff} : '0);
   assign p2_in = {p2_ff[PW-2:0], 1'b0} + (tn_ff[TW-1] ? {{TW{1'b0}}, acc_den_ff} : '0);
   assign pd_in = {pd_ff[PW-2:0], 1'b0} + (td_ff[TW-1] ? {{TW{1'b0}}, acc_den_ff} : '0);

   assign nn_sum = {1'b0, p1_ff[SW-1:0]} + {1'b0, p2_ff[SW-1:0]};

   assign status.term_den_zero = (in_term_den == '0);
   assign status.fits = ~|p1_ff[PW-1:SW] & ~|p2_ff[PW-1:SW] & ~|pd_ff[PW-1:SW]
                        & ~nn_sum[SW];
   assign status.gcd_done = (a_ff == '0) || (b_ff == '0);

   assign a_minus_b = a_ff - b_ff;
   assign b_minus_a = b_ff - a_ff;

   // When the GCD loop ends one operand is zero, so the OR is the odd part.
   assign divisor = a_ff | b_ff;
   assign rn_sh   = {rn_ff, qn_ff[SW-1]};
   assign rd_sh   = {rd_ff, qd_ff[SW-1]};
   assign rn_ge   = (rn_sh >= {1'b0, divisor});
   assign rd_ge   = (rd_sh >= {1'b0, divisor});

   // Accumulator and overflow flag carry reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_num_ff <= '0;
         acc_den_ff <= {{(SW-1){1'b0}}, 1'b1};
         ovf_ff     <= 1'b0;
      end else begin
         if (cmd.load && in_restart) begin
            acc_num_ff <= '0;
            acc_den_ff <= {{(SW-1){1'b0}}, 1'b1};
            ovf_ff     <= 1'b0;
         end
         if (cmd.check && !status.fits) begin
            ovf_ff <= 1'b1;
         end
         if (cmd.commit) begin
            acc_num_ff <= qn_ff;
            acc_den_ff <= qd_ff;
         end
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tn_ff   <= in_term_num;
         td_ff   <= in_term_den;
         zden_ff <= (in_term_den == '0);
         p1_ff   <= '0;
         p2_ff   <= '0;
         pd_ff   <= '0;
      end
      if (cmd.mul_step) begin
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         pd_ff <= pd_in;
         tn_ff <= {tn_ff[TW-2:0], 1'b0};
         td_ff <= {td_ff[TW-2:0], 1'b0};
      end
      if (cmd.check && status.fits) begin
         a_ff  <= pd_ff[SW-1:0];
         b_ff  <= nn_sum[SW-1:0];
         qd_ff <= pd_ff[SW-1:0];
         qn_ff <= nn_sum[SW-1:0];
         rn_ff <= '0;
         rd_ff <= '0;
      end
      if (cmd.gcd_step) begin
         if (!a_ff[0] && !b_ff[0]) begin
            // A common factor of two comes out of the dividends at once.
            a_ff  <= {1'b0, a_ff[SW-1:1]};
            b_ff  <= {1'b0, b_ff[SW-1:1]};
            qn_ff <= {1'b0, qn_ff[SW-1:1]};
            qd_ff <= {1'b0, qd_ff[SW-1:1]};
         end else if (!a_ff[0]) begin
            a_ff <= {1'b0, a_ff[SW-1:1]};
         end else if (!b_ff[0]) begin
            b_ff <= {1'b0, b_ff[SW-1:1]};
         end else if (a_ff >= b_ff) begin
            a_ff <= {1'b0, a_minus_b[SW-1:1]};
         end else begin
            b_ff <= {1'b0, b_minus_a[SW-1:1]};
         end
      end
      if (cmd.div_step) begin
         rn_ff <= rn_ge ? SW'(rn_sh - {1'b0, divisor}) : rn_sh[SW-1:0];
         rd_ff <= rd_ge ? SW'(rd_sh - {1'b0, divisor}) : rd_sh[SW-1:0];
         qn_ff <= {qn_ff[SW-2:0], rn_ge};
         qd_ff <= {qd_ff[SW-2:0], rd_ge};
      end
      if (cmd.out_load) begin
         res_num_ff  <= acc_num_ff;
         res_den_ff  <= acc_den_ff;
         res_ovf_ff  <= ovf_ff;
         res_zden_ff <= zden_ff;
      end
   end

   assign out_sum_num        = res_num_ff;
   assign out_sum_den        = res_den_ff;
   assign out_overflow       = res_ovf_ff;
   assign out_zero_den_error = res_zden_ff;

endmodule

>>> rtl/rational_sum_accumulator.sv
// Top level of the rational sum accumulator: stream ports, controller and
// datapath. Depends on rsa_pkg, rsa_ctrl and rsa_dp.
`timescale 1ns / 1ps

// The block keeps an exact fraction that starts at 0/1 and adds one rational
// term per input word, reducing the sum by its greatest common divisor.
// Input channel (req_): tdata carries the term numerator and denominator,
// tuser the restart flag, which clears the sum and the overflow flag to 0/1
// before the term is added. Result channel (rsp_): tdata carries the reduced
// numerator and denominator, tuser the sticky overflow flag and the flag for
// a term with a zero denominator, which is ignored.
// Exactly one result word follows every input word, in order.
// One word is worked on at a time. A term with a zero denominator goes from
// acceptance straight to the done state, which loads the result register
// once it is free. Any other term takes TERM_WIDTH multiply steps and one
// range check; if the sum fits, the binary GCD steps, a last pass through the
// GCD state to see the loop finish, SUM_WIDTH division steps and the commit
// state follow; the done state comes last. The shift-and-add multiplier and the
// restoring dividers work one bit a cycle.
// The result sits in an output register, so the next word is accepted while
// a result still waits; a stalled receiver holds the block only once the
// following result is ready. Reset clears the sum to 0/1, drops the overflow
// flag and empties the result register.

module rational_sum_accumulator #(
   parameter int TERM_WIDTH = rsa_pkg::TERM_WIDTH_DEFAULT,
   parameter int SUM_WIDTH  = rsa_pkg::SUM_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // term_num, term_den, zero fill
   input  logic [((2*TERM_WIDTH+7)/8)*8-1:0]   req_tdata,
   // restart
   input  logic [0:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // sum_num, sum_den, zero fill
   output logic [((2*SUM_WIDTH+7)/8)*8-1:0]    rsp_tdata,
   // overflow, zero_den_error
   output logic [1:0]                          rsp_tuser
);

   localparam int RSP_DW = ((2*SUM_WIDTH+7)/8)*8;

   rsa_pkg::rsa_cmd_type    cmd;
   rsa_pkg::rsa_status_type status;
   logic [SUM_WIDTH-1:0]    sum_num, sum_den;
   logic                    overflow, zero_den_error;

   rsa_ctrl #(
      .TERM_WIDTH (TERM_WIDTH),
      .SUM_WIDTH  (SUM_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rsa_dp #(
      .TERM_WIDTH (TERM_WIDTH),
      .SUM_WIDTH  (SUM_WIDTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .in_restart         (req_tuser[0]),
      .in_term_num        (req_tdata[TERM_WIDTH-1:0]),
      .in_term_den        (req_tdata[2*TERM_WIDTH-1:TERM_WIDTH]),
      .cmd                (cmd),
      .status             (status),
      .out_sum_num        (sum_num),
      .out_sum_den        (sum_den),
      .out_overflow       (overflow),
      .out_zero_den_error (zero_den_error)
   );

   // The fill bits above the two sum parts stay zero.
   always_comb begin
      rsp_tdata                  = {RSP_DW{1'b0}};
      rsp_tdata[2*SUM_WIDTH-1:0] = {sum_den, sum_num};
   end

   assign rsp_tuser = {zero_den_error, overflow};

endmodule

>>> rtl/rsa_checker.sv
// Port checker for the rational sum accumulator, bound to the top level.
// Depends on rsa_pkg and on rational_sum_accumulator's ports only.
`timescale 1ns / 1ps

module rsa_checker #(
   parameter int TERM_WIDTH = rsa_pkg::TERM_WIDTH_DEFAULT,
   parameter int SUM_WIDTH  = rsa_pkg::SUM_WIDTH_DEFAULT
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [((2*TERM_WIDTH+7)/8)*8-1:0]   req_tdata,
   input logic [0:0]                          req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [((2*SUM_WIDTH+7)/8)*8-1:0]    rsp_tdata,
   input logic [1:0]                          rsp_tuser
);

   logic [SUM_WIDTH-1:0] chk_num, chk_den;

   assign chk_num = rsp_tdata[SUM_WIDTH-1:0];
   assign chk_den = rsp_tdata[2*SUM_WIDTH-1:SUM_WIDTH];

   // A stalled result word holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsa_checker: stalled result word changed");

   // A waiting input word is held until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) && $stable(req_tuser))
      else $error("rsa_checker: waiting input word changed");

   // Reset empties the result register.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsa_checker: result valid after reset");

   // Only one word is in work at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("rsa_checker: input ready right after an accepted word");

   // Every reported sum has a nonzero denominator, and a zero sum is 0/1.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (chk_den != '0) && ((chk_num != '0) || (chk_den == 1)))
      else $error("rsa_checker: result sum is not reduced");

endmodule

bind rational_sum_accumulator rsa_checker #(
   .TERM_WIDTH (TERM_WIDTH),
   .SUM_WIDTH  (SUM_WIDTH)
) u_rsa_checker (.*);

>>> dv/rational_sum_accumulator_tb.sv
// Self-checking testbench for rational_sum_accumulator: drives terms on the
// req_ stream, predicts each reduced sum and checks every rsp_ word in order.
// Depends on rsa_pkg and the RTL of the block.
`timescale 1ns / 1ps

module rational_sum_accumulator_tb;

   localparam int TERM_W = rsa_pkg::TERM_WIDTH_DEFAULT;
   localparam int SUM_W  = rsa_pkg::SUM_WIDTH_DEFAULT;
   localparam int REQ_W  = ((2*TERM_W+7)/8)*8;
   localparam int RSP_W  = ((2*SUM_W+7)/8)*8;

   localparam logic [127:0] SUM_MAX = (128'd1 << SUM_W) - 128'd1;

   // The slowest legal run is roughly 1700 words plus the long output hold,
   // well inside this limit.
   localparam int LIMIT_CYCLES = 3_000_000;
   // Longer than one non-trivial term takes; waited out before the end.
   localparam int TAIL_CYCLES  = 400;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic [SUM_W-1:0] num;
      logic [SUM_W-1:0] den;
      logic             overflow;
      logic             zero_den;
   } sum_word_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;   // term_num, term_den
   logic [0:0]       req_tuser  = '0;   // restart
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;         // sum_num, sum_den, zero fill
   logic [1:0]       rsp_tuser;         // overflow, zero_den_error

   // Running sum as the block should hold it.
   logic [SUM_W-1:0] run_num      = '0;
   logic [SUM_W-1:0] run_den      = SUM_W'(1);
   logic             run_overflow = 1'b0;

   sum_word_type expected_sums[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_len      = 0;
   int hold_token    = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int cycle_count   = 0;

   int mismatch_count  = 0;
   int terms_sent      = 0;
   int restarts_sent   = 0;
   int zero_den_sent   = 0;
   int overflow_words  = 0;
   int words_checked   = 0;

   rational_sum_accumulator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Timed out after %0d cycles with %0d sums outstanding.",
                  cycle_count, expected_sums.size());
         $display("rational_sum_accumulator_tb NOT OK");
         $finish;
      end
   end

   // Adds one term to the running sum exactly as the block should, and
   // returns the word it must report.
   task automatic reduce_sum_after_term(input bit restart, input logic [TERM_W-1:0] tn,
                                        input logic [TERM_W-1:0] td,
                                        output sum_word_type word);
      logic [127:0] cross_num;
      logic [127:0] cross_den;
      logic [127:0] divisor;
      logic [127:0] rem;
      logic [127:0] step;
      if (restart) begin
         run_num      = '0;
         run_den      = SUM_W'(1);
         run_overflow = 1'b0;
      end
      word.zero_den = (td == '0);
      if (td != '0) begin
         cross_num = 128'(run_num) * 128'(td) + 128'(run_den) * 128'(tn);
         cross_den = 128'(run_den) * 128'(td);
         if (cross_num <= SUM_MAX && cross_den <= SUM_MAX) begin
            // Euclid; the denominator is at least one, so the divisor is too.
            divisor = cross_den;
            rem     = cross_num;
            while (rem != 0) begin
               step    = divisor % rem;
               divisor = rem;
               rem     = step;
            end
            run_num = SUM_W'(cross_num / divisor);
            run_den = SUM_W'(cross_den / divisor);
         end else begin
            run_overflow = 1'b1;
         end
      end
      word.num      = run_num;
      word.den      = run_den;
      word.overflow = run_overflow;
   endtask

   task automatic note_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("Mismatch at cycle %0d on %s: expected %0d, got %0d",
                  cycle_count, what, want, got);
   endtask

   task automatic check_sum_word();
      sum_word_type want;
      sum_word_type got;
      got.num      = rsp_tdata[SUM_W-1:0];
      got.den      = rsp_tdata[2*SUM_W-1:SUM_W];
      got.overflow = rsp_tuser[0];
      got.zero_den = rsp_tuser[1];
      words_checked++;
      if (expected_sums.size() == 0) begin
         note_mismatch("a sum word with none outstanding", 64'd0, 64'(got.num));
      end else begin
         want = expected_sums.pop_front();
         if (got.num != want.num)
            note_mismatch("sum_num", 64'(want.num), 64'(got.num));
         if (got.den != want.den)
            note_mismatch("sum_den", 64'(want.den), 64'(got.den));
         if (got.overflow != want.overflow)
            note_mismatch("overflow", 64'(want.overflow), 64'(got.overflow));
         if (got.zero_den != want.zero_den)
            note_mismatch("zero_den_error", 64'(want.zero_den), 64'(got.zero_den));
      end
   endtask

   // Result side: random stalls, a long hold when asked for, and the check of
   // each word taken at this edge.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_token != hold_seen) begin
            hold_seen  <= hold_token;
            hold_left  <= hold_len;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
         if (rsp_tvalid && rsp_tready)
            check_sum_word();
      end
   end

   // Offers one term and returns at the edge where the word is taken. Valid
   // stays high so a following call can go straight on without a gap.
   task automatic send_term(input bit restart, input logic [TERM_W-1:0] tn,
                            input logic [TERM_W-1:0] td);
      sum_word_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({td, tn});
      req_tuser  <= restart;
      do
         @(posedge clock);
      while (!req_tready);
      reduce_sum_after_term(restart, tn, td, want);
      expected_sums.push_back(want);
      terms_sent++;
      if (restart)
         restarts_sent++;
      if (td == '0)
         zero_den_sent++;
      if (want.overflow)
         overflow_words++;
   endtask

   task automatic wait_for_all_sums();
      req_tvalid <= 1'b0;
      while (expected_sums.size() != 0)
         @(posedge clock);
   endtask

   // Reset state, zero sums, zero denominators, restart and field extremes.
   task automatic test_edge_terms();
      send_term(1'b0, 32'd0, 32'd7);
      send_term(1'b0, 32'd1, 32'd3);
      send_term(1'b0, 32'd1, 32'd6);
      send_term(1'b0, 32'd0, 32'd0);
      send_term(1'b0, 32'hFFFF_FFFF, 32'd0);
      send_term(1'b1, 32'd5, 32'd10);
      send_term(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_term(1'b0, 32'hFFFF_FFFF, 32'd1);
      send_term(1'b1, 32'd0, 32'hFFFF_FFFF);
      send_term(1'b1, 32'd1, 32'd0);
      send_term(1'b0, 32'hAAAA_AAAA, 32'h5555_5555);
      send_term(1'b1, 32'h5555_5555, 32'hAAAA_AAAA);
   endtask

   // Overflow from the denominator, from one product and from the final
   // addition; the flag sticks through later terms until a restart.
   task automatic test_overflow_paths();
      send_term(1'b1, 32'd1, 32'hFFFF_FFFF);
      send_term(1'b0, 32'd1, 32'hFFFF_FFFE);
      send_term(1'b0, 32'd3, 32'd4);
      send_term(1'b0, 32'd0, 32'd0);
      send_term(1'b1, 32'hFFFF_FFFF, 32'd1);
      send_term(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
      send_term(1'b1, 32'hFFFF_FFFF, 32'd1);
      send_term(1'b0, 32'hFFFF_FFFF, 32'h8000_0000);
      send_term(1'b1, 32'd1, 32'd1);
   endtask

   // The receiver holds off long enough for the output register and the
   // datapath to fill, so the input stalls while terms are still offered.
   task automatic test_output_backpressure();
      int i;
      hold_len = 2500;
      hold_token++;
      send_term(1'b1, 32'd3, 32'd20);
      for (i = 0; i < 5; i++)
         send_term(1'b0, $urandom_range(1, 50), $urandom_range(1, 200));
   endtask

   // The sender stops until every sum has come back, then carries on with
   // the same running sum.
   task automatic test_drain_pause();
      int i;
      send_term(1'b1, 32'd2, 32'd7);
      for (i = 0; i < 2; i++)
         send_term(1'b0, $urandom_range(1, 30), $urandom_range(1, 100));
      wait_for_all_sums();
      for (i = 0; i < 3; i++)
         send_term(1'b0, $urandom_range(1, 30), $urandom_range(1, 100));
   endtask

   task automatic pick_term(output logic [TERM_W-1:0] tn, output logic [TERM_W-1:0] td);
      int kind;
      kind = $urandom_range(99);
      if (kind < 50) begin
         // A typical task: a short period and a utilisation of at most one.
         td = $urandom_range(1, 1000);
         tn = $urandom_range(1, td);
      end else if (kind < 65) begin
         td = $urandom_range(1, 65535);
         tn = $urandom_range(0, 65535);
      end else if (kind < 80) begin
         tn = $urandom;
         td = $urandom;
      end else if (kind < 86) begin
         tn = $urandom;
         td = '0;
      end else if (kind < 92) begin
         tn = '0;
         td = $urandom_range(1, 1000);
      end else begin
         case ($urandom_range(2))
            0: tn = '0;
            1: tn = 1;
            default: tn = '1;
         endcase
         case ($urandom_range(2))
            0: td = 1;
            1: td = 32'h8000_0000;
            default: td = '1;
         endcase
      end
   endtask

   // Mostly task sets that open with a restart; some continue the previous
   // sum, often one already overflowed, and a few restart part way through.
   task automatic test_random_sums(input int term_count);
      int counted;
      int set_len;
      int i;
      bit restart;
      logic [TERM_W-1:0] tn;
      logic [TERM_W-1:0] td;
      counted = 0;
      while (counted < term_count) begin
         set_len = $urandom_range(1, 12);
         for (i = 0; i < set_len; i++) begin
            if (i == 0)
               restart = ($urandom_range(99) < 80);
            else
               restart = ($urandom_range(99) < 3);
            pick_term(tn, td);
            send_term(restart, tn, td);
            if (td != '0)
               counted++;
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 31;
      recv_idle_pct = 76;
      test_edge_terms();
      test_overflow_paths();
      test_output_backpressure();
      test_drain_pause();
      test_random_sums(510);

      send_idle_pct = 76;
      recv_idle_pct = 31;
      test_random_sums(510);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_sums(510);

      wait_for_all_sums();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Summed %0d terms with %0d restarts and %0d zero denominators; %0d words",
               terms_sent, restarts_sent, zero_den_sent, words_checked);
      $display("checked, %0d carrying the overflow flag, under three idle mixes and a long hold.",
               overflow_words);
      if (mismatch_count == 0 && expected_sums.size() == 0) begin
         $display("rational_sum_accumulator_tb OK");
      end else begin
         $display("%0d mismatches, %0d sums outstanding.", mismatch_count,
                  expected_sums.size());
         $display("rational_sum_accumulator_tb NOT OK");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/rsa_pkg.sv
rtl/rsa_ctrl.sv
rtl/rsa_dp.sv
rtl/rational_sum_accumulator.sv
rtl/rsa_checker.sv
dv/rational_sum_accumulator_tb.sv
